FILE: design/md5e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5e_pkg
// Shared types, constants and round tables of the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5e_pkg;

	localparam int WordW      = 32;
	localparam int BufWords   = 16;
	localparam int BlockBytes = 64;
	localparam int PadLimit   = 56;
	localparam int Rounds     = 64;
	localparam int CmdQDepth  = 2;
	localparam int CmdQPtrW   = $clog2(CmdQDepth);

	localparam logic [3:0][WordW-1:0] IvWords = {
		32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	localparam logic [7:0] PadByte = 8'h80;

	typedef struct packed {
		logic [WordW-1:0] data;
		logic [2:0]       nbytes;
		logic             last;
	} cmd_t;

	function automatic logic [4:0] rot_amount(input logic [1:0] phase, input logic [1:0] sel);
		logic [4:0] r;
		r = 5'd7;
		case ({phase, sel})
			4'h0: r = 5'd7;   4'h1: r = 5'd12;  4'h2: r = 5'd17;  4'h3: r = 5'd22;
			4'h4: r = 5'd5;   4'h5: r = 5'd9;   4'h6: r = 5'd14;  4'h7: r = 5'd20;
			4'h8: r = 5'd4;   4'h9: r = 5'd11;  4'ha: r = 5'd16;  4'hb: r = 5'd23;
			4'hc: r = 5'd6;   4'hd: r = 5'd10;  4'he: r = 5'd15;  4'hf: r = 5'd21;
			default: r = 5'd7;
		endcase
		return r;
	endfunction

	function automatic logic [WordW-1:0] round_k(input logic [5:0] i);
		logic [WordW-1:0] k;
		k = 32'h0;
		case (i)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

FILE: design/md5e_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5e_front
// Input side: clamps the byte count, drops empty non-final words and
// forwards commands to the command queue.
// ----------------------------------------------------------------------------
module md5e_front (
	input  wire logic                     push,
	output logic                          full,
	input  wire logic [31:0]              data_word,
	input  wire logic [2:0]               byte_count,
	input  wire logic                     last,
	input  wire logic                     q_full,
	output logic                          q_push,
	output md5e_pkg::cmd_t                q_cmd
);

	logic [2:0] nbytes;
	logic       keep;

	assign nbytes = (byte_count > 3'd4) ? 3'd4 : byte_count;
	// an empty word that does not end the message changes nothing
	assign keep   = last || (nbytes != 3'd0);

	assign full          = q_full;
	assign q_push        = push && !q_full && keep;
	assign q_cmd.data    = data_word;
	assign q_cmd.nbytes  = nbytes;
	assign q_cmd.last    = last;

endmodule
`default_nettype wire

FILE: design/md5e_cmdq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5e_cmdq
// Short command queue between the input side and the hash core.
// ----------------------------------------------------------------------------
module md5e_cmdq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire md5e_pkg::cmd_t din,
	output logic                full,
	input  wire logic           pop,
	output md5e_pkg::cmd_t      dout,
	output logic                empty
);

	md5e_pkg::cmd_t                 mem_q [md5e_pkg::CmdQDepth];
	logic [md5e_pkg::CmdQPtrW-1:0]  wr_ptr_q;
	logic [md5e_pkg::CmdQPtrW-1:0]  rd_ptr_q;
	logic [md5e_pkg::CmdQPtrW:0]    cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign full    = (cnt_q == (md5e_pkg::CmdQPtrW+1)'(md5e_pkg::CmdQDepth));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == (md5e_pkg::CmdQPtrW)'(md5e_pkg::CmdQDepth - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == (md5e_pkg::CmdQPtrW)'(md5e_pkg::CmdQDepth - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/md5e_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5e_back
// Hash core: packs bytes into the block buffer, pads, runs the 64-round
// compression one round per cycle and holds the digest for readout.
// ----------------------------------------------------------------------------
module md5e_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire md5e_pkg::cmd_t q_cmd,
	output logic                q_pop,
	output logic                empty,
	input  wire logic           pop,
	output logic [31:0]         digest_word,
	output logic [1:0]          word_index,
	output logic                final_word
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_PAD  = 3'd2;
	localparam logic [2:0] S_LEN  = 3'd3;
	localparam logic [2:0] S_RND  = 3'd4;
	localparam logic [2:0] S_ADD  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	localparam logic [5:0] LastRound  = 6'(md5e_pkg::Rounds - 1);
	localparam logic [6:0] BlockBytes = 7'(md5e_pkg::BlockBytes);
	localparam logic [6:0] PadLimit   = 7'(md5e_pkg::PadLimit);

	logic [2:0]  state_q;
	logic [31:0] chain_q [4];
	logic [31:0] buf_q   [md5e_pkg::BufWords];
	logic [31:0] buf_d   [md5e_pkg::BufWords];
	logic [6:0]  fill_q;
	logic [63:0] bitlen_q;
	logic [31:0] word_q;
	logic [2:0]  rem_q;
	logic        last_q;
	logic        pad_done_q;
	logic        len_done_q;
	logic [5:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] dig_q [4];
	logic [1:0]  out_idx_q;
	logic        out_vld_q;

	logic [6:0]  space;
	logic [2:0]  fit;
	logic [6:0]  fill_ins;
	logic [5:0]  ins_pos [4];
	logic [1:0]  phase;
	logic [3:0]  g;
	logic [31:0] f;
	logic [31:0] t;
	logic [4:0]  s;
	logic [31:0] rot;
	logic [31:0] b_new;

	assign space    = BlockBytes - fill_q;
	assign fit      = ({4'd0, rem_q} < space) ? rem_q : space[2:0];
	assign fill_ins = fill_q + 7'(fit);

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			ins_pos[j] = fill_q[5:0] + 6'(j);
		end
	end

	// one round of the compression
	assign phase = rnd_q[5:4];
	always_comb begin
		f = 32'h0;
		g = 4'h0;
		case (phase)
			2'd0: begin
				f = (b_q & c_q) | (~b_q & d_q);
				g = rnd_q[3:0];
			end
			2'd1: begin
				f = (d_q & b_q) | (~d_q & c_q);
				g = 4'(rnd_q[3:0] * 4'd5 + 4'd1);
			end
			2'd2: begin
				f = b_q ^ c_q ^ d_q;
				g = 4'(rnd_q[3:0] * 4'd3 + 4'd5);
			end
			default: begin
				f = c_q ^ (b_q | ~d_q);
				g = 4'(rnd_q[3:0] * 4'd7);
			end
		endcase
	end

	assign t     = f + a_q + md5e_pkg::round_k(rnd_q) + buf_q[g];
	assign s     = md5e_pkg::rot_amount(phase, rnd_q[1:0]);
	assign rot   = (t << s) | (t >> (6'd32 - {1'b0, s}));
	assign b_new = b_q + rot;

	always_comb begin
		buf_d = buf_q;
		case (state_q)
			S_INS: begin
				for (int j = 0; j < 4; j++) begin
					if (3'(j) < fit) begin
						buf_d[ins_pos[j][5:2]][{ins_pos[j][1:0], 3'b000} +: 8] =
							word_q[j*8 +: 8];
					end
				end
			end
			S_PAD: begin
				buf_d[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] = md5e_pkg::PadByte;
			end
			S_LEN: begin
				buf_d[14] = bitlen_q[31:0];
				buf_d[15] = bitlen_q[63:32];
			end
			S_ADD: begin
				for (int j = 0; j < md5e_pkg::BufWords; j++) begin
					buf_d[j] = 32'h0;
				end
			end
			default: begin
				buf_d = buf_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < md5e_pkg::BufWords; j++) begin
				buf_q[j] <= 32'h0;
			end
		end else begin
			buf_q <= buf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && !out_vld_q) begin
			for (int j = 0; j < 4; j++) begin
				dig_q[j] <= chain_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			for (int j = 0; j < 4; j++) begin
				chain_q[j] <= md5e_pkg::IvWords[j];
			end
			fill_q     <= '0;
			bitlen_q   <= '0;
			word_q     <= '0;
			rem_q      <= '0;
			last_q     <= 1'b0;
			pad_done_q <= 1'b0;
			len_done_q <= 1'b0;
			rnd_q      <= '0;
			a_q        <= '0;
			b_q        <= '0;
			c_q        <= '0;
			d_q        <= '0;
			out_idx_q  <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_vld_q && pop) begin
				out_idx_q <= out_idx_q + 1'b1;
				if (out_idx_q == 2'd3) begin
					out_vld_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						word_q  <= q_cmd.data;
						rem_q   <= q_cmd.nbytes;
						last_q  <= q_cmd.last;
						state_q <= S_INS;
					end
				end
				S_INS: begin
					fill_q   <= fill_ins;
					bitlen_q <= bitlen_q + {58'd0, fit, 3'b000};
					word_q   <= word_q >> {fit, 3'b000};
					rem_q    <= rem_q - fit;
					if (fill_ins == BlockBytes) begin
						a_q     <= chain_q[0];
						b_q     <= chain_q[1];
						c_q     <= chain_q[2];
						d_q     <= chain_q[3];
						rnd_q   <= '0;
						state_q <= S_RND;
					end else if (last_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PAD: begin
					fill_q     <= fill_q + 7'd1;
					pad_done_q <= 1'b1;
					if (fill_q + 7'd1 > PadLimit) begin
						a_q     <= chain_q[0];
						b_q     <= chain_q[1];
						c_q     <= chain_q[2];
						d_q     <= chain_q[3];
						rnd_q   <= '0;
						state_q <= S_RND;
					end else begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					len_done_q <= 1'b1;
					a_q        <= chain_q[0];
					b_q        <= chain_q[1];
					c_q        <= chain_q[2];
					d_q        <= chain_q[3];
					rnd_q      <= '0;
					state_q    <= S_RND;
				end
				S_RND: begin
					a_q   <= d_q;
					d_q   <= c_q;
					c_q   <= b_q;
					b_q   <= b_new;
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == LastRound) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					fill_q     <= '0;
					if (rem_q != 3'd0) begin
						state_q <= S_INS;
					end else if (!last_q) begin
						state_q <= S_IDLE;
					end else if (!pad_done_q) begin
						state_q <= S_PAD;
					end else if (!len_done_q) begin
						state_q <= S_LEN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_vld_q) begin
						out_vld_q  <= 1'b1;
						out_idx_q  <= '0;
						for (int j = 0; j < 4; j++) begin
							chain_q[j] <= md5e_pkg::IvWords[j];
						end
						bitlen_q   <= '0;
						fill_q     <= '0;
						last_q     <= 1'b0;
						pad_done_q <= 1'b0;
						len_done_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign q_pop       = (state_q == S_IDLE) && !q_empty;
	assign empty       = !out_vld_q;
	assign digest_word = dig_q[out_idx_q];
	assign word_index  = out_idx_q;
	assign final_word  = (out_idx_q == 2'd3);

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= BlockBytes)
		else $error("block fill beyond one block");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |-> out_idx_q == 2'd0)
		else $error("digest index not back at word A");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_vld_q) |=> (out_vld_q && state_q == S_IDLE))
		else $error("digest not loaded");

	a_rnd_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RND && rnd_q == LastRound) |=> state_q == S_ADD)
		else $error("compression did not end after the last round");

endmodule
`default_nettype wire

FILE: design/md5_hash_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5_hash_engine_core
// MD5 digest engine with queue-style input and digest ports.
// ----------------------------------------------------------------------------
// Message bytes arrive packed little-endian in 32-bit words with a byte count
// and a last flag; the message may end or pause at any byte. Each input word
// passes through the idle and insert states of the core, and every completed
// 64-byte block then runs the compression, one round per cycle, and a chaining
// add. The last word adds padding and length writes plus one or two
// compressions, after which four digest words (A to D, little-endian byte
// order) are offered; the next message may enter while they are drained,
// and a two-entry command queue absorbs input bursts.
// ----------------------------------------------------------------------------
module md5_hash_engine_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      digest_word,
	output logic [1:0]       word_index,
	output logic             final_word
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_empty;
	md5e_pkg::cmd_t q_in;
	md5e_pkg::cmd_t q_out;

	md5e_front u_front (
		.push       (push),
		.full       (full),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_in)
	);

	md5e_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_out),
		.empty  (q_empty)
	);

	md5e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_cmd       (q_out),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.final_word  (final_word)
	);

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for md5_hash_engine_core.
// ----------------------------------------------------------------------------
// Messages are fed as byte-packed words: a short directed table (empty and
// three-byte messages with known digests, field extremes, odd byte counts,
// the 56-byte padding boundary), then random messages weighted toward block
// and padding boundaries. A behavioral MD5 model predicts the four digest
// words of each message and every popped word is compared in order. Input
// gaps and output stalls vary by phase.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic [md5e_pkg::WordW-1:0] word;
		logic [1:0]                 index;
		logic                       fin;
	} digest_xfer_t;

	typedef struct packed {
		logic [md5e_pkg::WordW-1:0] data;
		logic [2:0]                 nbytes;
		logic                       lst;
		logic [7:0]                 reps;
		logic                       known;
		logic [127:0]               digest;
	} stim_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       push = 1'b0;
	logic                       full;
	logic [md5e_pkg::WordW-1:0] data_word = '0;
	logic [2:0]                 byte_count = '0;
	logic                       last = 1'b0;
	logic                       empty;
	logic                       pop = 1'b0;
	logic [md5e_pkg::WordW-1:0] digest_word;
	logic [1:0]                 word_index;
	logic                       final_word;

	md5_hash_engine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_word(data_word),
		.byte_count(byte_count),
		.last(last),
		.empty(empty),
		.pop(pop),
		.digest_word(digest_word),
		.word_index(word_index),
		.final_word(final_word)
	);

	digest_xfer_t     digests_due[$];
	logic [31:0]      sine_tab [64];
	logic [4:0]       shift_tab [16];
	logic [31:0]      chain_q [4];
	logic [31:0]      msg_blk [16];
	int unsigned      blk_fill;
	logic [63:0]      msg_bits;
	logic             known_valid = 1'b0;
	logic [127:0]     known_digest = '0;
	int               gap_pct = 0;
	int               stall_pct = 0;
	int               n_fail = 0;
	int               n_msgs = 0;
	int               n_words = 0;
	int               n_digest = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic void md5_restart();
		int i;
		chain_q[0] = 32'h67452301;
		chain_q[1] = 32'hefcdab89;
		chain_q[2] = 32'h98badcfe;
		chain_q[3] = 32'h10325476;
		for (i = 0; i < 16; i++)
			msg_blk[i] = '0;
		blk_fill = 0;
		msg_bits = '0;
	endfunction

	function automatic void md5_compress();
		logic [31:0] a, b, c, d, f, t;
		int g, i, s;
		a = chain_q[0];
		b = chain_q[1];
		c = chain_q[2];
		d = chain_q[3];
		for (i = 0; i < 64; i++) begin
			case (i / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = 5 * i + 1;
				end
				2: begin
					f = b ^ c ^ d;
					g = 3 * i + 5;
				end
				default: begin
					f = c ^ (b | ~d);
					g = 7 * i;
				end
			endcase
			t = f + a + sine_tab[i] + msg_blk[g % 16];
			s = shift_tab[4 * (i / 16) + i % 4];
			a = d;
			d = c;
			c = b;
			b = b + ((t << s) | (t >> (32 - s)));
		end
		chain_q[0] = chain_q[0] + a;
		chain_q[1] = chain_q[1] + b;
		chain_q[2] = chain_q[2] + c;
		chain_q[3] = chain_q[3] + d;
		for (i = 0; i < 16; i++)
			msg_blk[i] = '0;
	endfunction

	function automatic void md5_put_byte(input logic [7:0] v);
		msg_blk[blk_fill / 4][8 * (blk_fill % 4) +: 8] = v;
		blk_fill++;
	endfunction

	// returns 1 when the word closes a message, with the digest as {D, C, B, A}
	function automatic bit md5_absorb(input logic [31:0] w, input logic [2:0] cnt,
			input logic lst, output logic [127:0] dg);
		int n, k;
		n = (cnt > 3'd4) ? 4 : cnt;
		dg = '0;
		for (k = 0; k < n; k++) begin
			md5_put_byte(w[8 * k +: 8]);
			msg_bits = msg_bits + 64'd8;
			if (blk_fill == 64) begin
				md5_compress();
				blk_fill = 0;
			end
		end
		if (!lst)
			return 1'b0;
		md5_put_byte(8'h80);
		if (blk_fill > 56) begin
			md5_compress();
			blk_fill = 0;
		end
		msg_blk[14] = msg_bits[31:0];
		msg_blk[15] = msg_bits[63:32];
		md5_compress();
		dg = {chain_q[3], chain_q[2], chain_q[1], chain_q[0]};
		md5_restart();
		return 1'b1;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(15))
			0: return 32'h0;
			1: return 32'hffffffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
		logic [127:0] dg;
		digest_xfer_t e;
		int k;
		push <= 1'b1;
		data_word <= w;
		byte_count <= cnt;
		last <= lst;
		@(posedge clk);
		while (full)
			@(posedge clk);
		n_words++;
		if (md5_absorb(w, cnt, lst, dg)) begin
			if (known_valid)
				dg = known_digest;
			for (k = 0; k < 4; k++) begin
				e.word = dg[32 * k +: 32];
				e.index = k[1:0];
				e.fin = (k == 3);
				digests_due.push_back(e);
			end
			n_msgs++;
		end
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct)
				@(posedge clk);
		end
	endtask

	// digest side: check each transfer, then pick the next pop
	initial begin
		digest_xfer_t want;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (digests_due.size() == 0) begin
					$error("unexpected digest transfer: digest_word %h", digest_word);
					n_fail++;
				end else begin
					want = digests_due.pop_front();
					n_digest++;
					if (digest_word !== want.word) begin
						$error("digest_word: expected %h, actual %h", want.word, digest_word);
						n_fail++;
					end
					if (word_index !== want.index) begin
						$error("word_index: expected %0d, actual %0d", want.index, word_index);
						n_fail++;
					end
					if (final_word !== want.fin) begin
						$error("final_word: expected %0d, actual %0d", want.fin, final_word);
						n_fail++;
					end
				end
			end
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		stim_row_t rows [12];
		int r, j, nw, tgt, lc, cnt, n_rand, msg_idx;
		int edges [10];
		sine_tab = '{
			32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
			32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
			32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
			32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
			32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
			32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
			32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
			32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
			32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
			32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
			32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
			32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
			32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
			32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
			32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
			32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
		};
		shift_tab = '{
			5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
			5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
		};
		edges = '{55, 56, 57, 60, 63, 64, 65, 119, 120, 121};
		md5_restart();

		// empty message, data bits ignored
		rows[0]  = '{32'hffffffff, 3'd0, 1'b1, 8'd1, 1'b1,
			{32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4}};
		// "abc"
		rows[1]  = '{32'h00636261, 3'd3, 1'b1, 8'd1, 1'b1,
			{32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190}};
		// two messages: extremes, zero-byte word, short words, counts above four
		rows[2]  = '{32'h00000000, 3'd4, 1'b0, 8'd1, 1'b0, 128'h0};
		rows[3]  = '{32'hffffffff, 3'd4, 1'b0, 8'd1, 1'b0, 128'h0};
		rows[4]  = '{32'hdeadbeef, 3'd0, 1'b0, 8'd1, 1'b0, 128'h0};
		rows[5]  = '{32'h5a5a5aa5, 3'd1, 1'b0, 8'd1, 1'b0, 128'h0};
		rows[6]  = '{32'hc3c3f00f, 3'd2, 1'b0, 8'd1, 1'b0, 128'h0};
		rows[7]  = '{32'h12345678, 3'd7, 1'b0, 8'd1, 1'b0, 128'h0};
		rows[8]  = '{32'hffffffff, 3'd5, 1'b1, 8'd1, 1'b0, 128'h0};
		rows[9]  = '{32'h89abcdef, 3'd6, 1'b1, 8'd1, 1'b0, 128'h0};
		// 56 bytes: padding needs an extra block
		rows[10] = '{32'ha5a5a5a5, 3'd4, 1'b0, 8'd14, 1'b0, 128'h0};
		rows[11] = '{32'h00000000, 3'd0, 1'b1, 8'd1, 1'b0, 128'h0};

		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < 12; r++) begin
			known_valid = rows[r].known;
			known_digest = rows[r].digest;
			for (j = 0; j < rows[r].reps; j++)
				send_word(rows[r].data, rows[r].nbytes, rows[r].lst);
		end
		known_valid = 1'b0;

		n_rand = 0;
		msg_idx = 0;
		while (n_rand < 245) begin
			case ((msg_idx / 2) % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 52;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 52;
				end
				default: begin
					gap_pct = 6;
					stall_pct = 6;
				end
			endcase
			if ($urandom_range(9) < 3) begin
				// lengths around block and padding boundaries
				tgt = edges[$urandom_range(9)];
				for (j = 0; j < tgt / 4; j++)
					send_word(rand_word(), 3'd4, 1'b0);
				n_rand += tgt / 4;
				lc = tgt % 4;
			end else begin
				nw = ($urandom_range(9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 24);
				for (j = 0; j < nw; j++) begin
					cnt = ($urandom_range(9) == 0) ? $urandom_range(7) : 4;
					send_word(rand_word(), cnt[2:0], 1'b0);
					if (cnt != 0)
						n_rand++;
				end
				lc = $urandom_range(7);
			end
			send_word(rand_word(), lc[2:0], 1'b1);
			n_rand++;
			msg_idx++;
		end
		push <= 1'b0;

		while (digests_due.size() != 0)
			@(posedge clk);
		stall_pct = 0;
		repeat (300)
			@(posedge clk);

		$display("sent %0d input words in %0d messages, checked %0d digest words",
			n_words, n_msgs, n_digest);
		$display("phases: free flow, input gaps, output stalls, light mix; %0d mismatches",
			n_fail);
		if (n_fail == 0 && digests_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: md5_hash_engine_core.f
design/md5e_pkg.sv
design/md5e_front.sv
design/md5e_cmdq.sv
design/md5e_back.sv
design/md5_hash_engine_core.sv
tb/sv/tb.sv
